// File: sv/lpfc_pkg.sv
// Shared types and constants for the LVDT and pressure frame conditioner.
package lpfc_pkg;

  localparam int GAIN_W    = 24;
  localparam int OFFSET_W  = 16;
  localparam int POS_W     = 20;
  localparam int DISP_W    = 21;
  localparam int RATE_W    = 32;
  localparam int PRESS_W   = 16;
  localparam int ELAPSED_W = 32;
  localparam int MUL_A_W   = 21;
  localparam int PROD_W    = MUL_A_W + GAIN_W;
  localparam int Q_SHIFT   = 16;
  localparam int MAG_W     = 41;
  localparam int DIV_CNT_W = 6;

  localparam logic [GAIN_W-1:0]   RATE_SCALE     = 24'd1000000;
  localparam logic [GAIN_W-1:0]   LVDT_GAIN_RST  = 24'd65536;
  localparam logic [GAIN_W-1:0]   PRESS_GAIN_RST = 24'd332766;
  localparam logic [OFFSET_W-1:0] PRESS_OFFS_RST = 16'd161;

  typedef struct packed {
    logic       accum;
    logic       div_start;
    logic       rate_path;
    logic       avg_store;
    logic       mul_go;
    logic       scale_store;
    logic       disp_calc;
    logic       rate_store;
    logic       finish;
    logic [1:0] idx;
  } lpfc_cmd_t;

  typedef struct packed {
    logic last_item;
    logic calibrated;
    logic elapsed_zero;
    logic div_done;
  } lpfc_status_t;

endpackage

// File: sv/lvdt_pressure_frame_conditioner.sv
// Top level of the LVDT and pressure frame conditioner.
//
// Input channel (in_valid/in_ready): one beat per scan position carrying two
// displacement samples, two pressure samples and elapsed_us. After SAMPLES
// beats the block averages each channel, scales with the Q16 gains and
// emits one result beat on the output channel (out_valid/out_ready).
// The first frame after reset captures the zero biases (bias_captured set).
// A non-final beat is only accumulated and the block stays ready. The final
// beat of a frame occupies the block for four averages by reciprocal
// multiply, four Q16 scalings, then two rate quotients one bit per cycle
// through the single shared serial divider. A bias frame or a frame with
// zero elapsed time skips the rates. in_ready is low while a frame is
// computed. The result sits in an output register; a stalled receiver only
// holds the block once the next frame is finished. Configuration writes go
// through the APB port; the user must write them only while idle, since the
// block itself does not enforce it. Reset restores register defaults, clears
// sums, counter, biases and the output valid.
module lvdt_pressure_frame_conditioner #(
  parameter int SAMPLES     = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               disp1_raw,
  input  logic [SAMPLE_BITS-1:0]               disp2_raw,
  input  logic [SAMPLE_BITS-1:0]               press1_raw,
  input  logic [SAMPLE_BITS-1:0]               press2_raw,
  input  logic [lpfc_pkg::ELAPSED_W-1:0]       elapsed_us,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lpfc_pkg::DISP_W-1:0]   disp1,
  output logic signed [lpfc_pkg::DISP_W-1:0]   disp2,
  output logic signed [lpfc_pkg::RATE_W-1:0]   rate1,
  output logic signed [lpfc_pkg::RATE_W-1:0]   rate2,
  output logic [lpfc_pkg::PRESS_W-1:0]         pressure1,
  output logic [lpfc_pkg::PRESS_W-1:0]         pressure2,
  output logic                                 bias_captured,
  output logic                                 rate_invalid
);
  import lpfc_pkg::*;

  logic [GAIN_W-1:0]   lvdt1_gain;
  logic [GAIN_W-1:0]   lvdt2_gain;
  logic [GAIN_W-1:0]   pressure_gain;
  logic [OFFSET_W-1:0] pressure_offset;
  lpfc_cmd_t           cmd;
  lpfc_status_t        status;

  lpfc_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .lvdt1_gain      (lvdt1_gain),
    .lvdt2_gain      (lvdt2_gain),
    .pressure_gain   (pressure_gain),
    .pressure_offset (pressure_offset)
  );

  lpfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpfc_dp #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .disp1_raw       (disp1_raw),
    .disp2_raw       (disp2_raw),
    .press1_raw      (press1_raw),
    .press2_raw      (press2_raw),
    .elapsed_us      (elapsed_us),
    .lvdt1_gain      (lvdt1_gain),
    .lvdt2_gain      (lvdt2_gain),
    .pressure_gain   (pressure_gain),
    .pressure_offset (pressure_offset),
    .disp1           (disp1),
    .disp2           (disp2),
    .rate1           (rate1),
    .rate2           (rate2),
    .pressure1       (pressure1),
    .pressure2       (pressure2),
    .bias_captured   (bias_captured),
    .rate_invalid    (rate_invalid)
  );

endmodule

// File: sv/lpfc_regs.sv
// APB configuration registers: gains and pressure offset.
module lpfc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [lpfc_pkg::GAIN_W-1:0]    lvdt1_gain,
  output logic [lpfc_pkg::GAIN_W-1:0]    lvdt2_gain,
  output logic [lpfc_pkg::GAIN_W-1:0]    pressure_gain,
  output logic [lpfc_pkg::OFFSET_W-1:0]  pressure_offset
);
  import lpfc_pkg::*;

  typedef enum logic [1:0] {
    REG_LVDT1_GAIN,
    REG_LVDT2_GAIN,
    REG_PRESS_GAIN,
    REG_PRESS_OFFSET
  } reg_idx_t;

  reg_idx_t sel_reg;
  logic     wr_en;

  assign sel_reg = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvdt1_gain      <= LVDT_GAIN_RST;
      lvdt2_gain      <= LVDT_GAIN_RST;
      pressure_gain   <= PRESS_GAIN_RST;
      pressure_offset <= PRESS_OFFS_RST;
    end else if (wr_en) begin
      unique case (sel_reg)
        REG_LVDT1_GAIN:   lvdt1_gain      <= pwdata[GAIN_W-1:0];
        REG_LVDT2_GAIN:   lvdt2_gain      <= pwdata[GAIN_W-1:0];
        REG_PRESS_GAIN:   pressure_gain   <= pwdata[GAIN_W-1:0];
        REG_PRESS_OFFSET: pressure_offset <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_reg)
      REG_LVDT1_GAIN:   prdata = 32'(lvdt1_gain);
      REG_LVDT2_GAIN:   prdata = 32'(lvdt2_gain);
      REG_PRESS_GAIN:   prdata = 32'(pressure_gain);
      REG_PRESS_OFFSET: prdata = 32'(pressure_offset);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: sv/lpfc_div.sv
// Restoring serial divider, one quotient bit per cycle, left-aligned dividend.
module lpfc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lpfc_pkg::MAG_W-1:0]       dividend,
  input  logic [lpfc_pkg::ELAPSED_W-1:0]   divisor,
  input  logic [lpfc_pkg::DIV_CNT_W-1:0]   iters,
  output logic [lpfc_pkg::MAG_W-1:0]       quotient,
  output logic                             done
);
  import lpfc_pkg::*;

  logic                   busy;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [ELAPSED_W-1:0]   rem;
  logic [ELAPSED_W-1:0]   dsor;
  logic [ELAPSED_W:0]     trial;
  logic                   ge;
  logic [ELAPSED_W:0]     rem_next;

  always_comb begin
    trial    = {rem, quotient[MAG_W-1]};
    ge       = trial >= {1'b0, dsor};
    rem_next = ge ? trial - {1'b0, dsor} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsor     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next[ELAPSED_W-1:0];
      quotient <= {quotient[MAG_W-2:0], ge};
    end
  end

endmodule

// File: sv/lpfc_dp.sv
// Datapath: sums, averages, Q16 scaling, bias, rate and result registers.
module lpfc_dp #(
  parameter int SAMPLES     = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpfc_pkg::lpfc_cmd_t                  cmd,
  output lpfc_pkg::lpfc_status_t               status,
  input  logic [SAMPLE_BITS-1:0]               disp1_raw,
  input  logic [SAMPLE_BITS-1:0]               disp2_raw,
  input  logic [SAMPLE_BITS-1:0]               press1_raw,
  input  logic [SAMPLE_BITS-1:0]               press2_raw,
  input  logic [lpfc_pkg::ELAPSED_W-1:0]       elapsed_us,
  input  logic [lpfc_pkg::GAIN_W-1:0]          lvdt1_gain,
  input  logic [lpfc_pkg::GAIN_W-1:0]          lvdt2_gain,
  input  logic [lpfc_pkg::GAIN_W-1:0]          pressure_gain,
  input  logic [lpfc_pkg::OFFSET_W-1:0]        pressure_offset,
  output logic signed [lpfc_pkg::DISP_W-1:0]   disp1,
  output logic signed [lpfc_pkg::DISP_W-1:0]   disp2,
  output logic signed [lpfc_pkg::RATE_W-1:0]   rate1,
  output logic signed [lpfc_pkg::RATE_W-1:0]   rate2,
  output logic [lpfc_pkg::PRESS_W-1:0]         pressure1,
  output logic [lpfc_pkg::PRESS_W-1:0]         pressure2,
  output logic                                 bias_captured,
  output logic                                 rate_invalid
);
  import lpfc_pkg::*;

  localparam int SUM_W      = SAMPLE_BITS + $clog2(SAMPLES);
  localparam int CNT_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SC_W       = PROD_W - Q_SHIFT;
  localparam int AVG_SHIFT  = SUM_W + 3;
  localparam int RECIP_W    = AVG_SHIFT + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam longint unsigned AVG_RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_FULL);

  logic [SUM_W-1:0]        sums [4];
  logic [SAMPLE_BITS-1:0]  raw  [4];
  logic [CNT_W-1:0]        count;
  logic                    calibrated;
  logic [ELAPSED_W-1:0]    elapsed;
  logic [SAMPLE_BITS-1:0]  avg  [4];
  logic [POS_W-1:0]        pos  [2];
  logic [POS_W-1:0]        bias [2];
  logic [PRESS_W-1:0]      press [2];
  logic [DISP_W-1:0]       disp [2];
  logic [DISP_W-1:0]       last [2];
  logic [MUL_A_W-1:0]      dmag [2];
  logic                    dneg [2];
  logic [RATE_W-1:0]       rate [2];
  logic [PROD_W-1:0]       prod;

  logic [MUL_A_W-1:0]      mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic [GAIN_W-1:0]       gain_sel;
  logic [MAG_W-1:0]        div_dividend;
  logic [ELAPSED_W-1:0]    div_divisor;
  logic [DIV_CNT_W-1:0]    div_iters;
  logic [MAG_W-1:0]        quo;
  logic                    div_done;
  logic [AVG_PROD_W-1:0]   avg_prod;
  logic [SC_W-1:0]         scaled;
  logic [SC_W:0]           press_sum;
  logic [POS_W-1:0]        pos_sat;
  logic [PRESS_W-1:0]      press_sat;
  logic [RATE_W-1:0]       rate_sat;
  logic                    quo_big;
  logic [DISP_W-1:0]       disp_new [2];
  logic [DISP_W:0]         diff [2];
  logic [DISP_W:0]         diff_abs [2];

  assign raw[0] = disp1_raw;
  assign raw[1] = disp2_raw;
  assign raw[2] = press1_raw;
  assign raw[3] = press2_raw;

  assign status.last_item    = (count == CNT_W'(SAMPLES - 1));
  assign status.calibrated   = calibrated;
  assign status.elapsed_zero = (elapsed == '0);
  assign status.div_done     = div_done;

  always_comb begin
    unique case (cmd.idx)
      2'd0:    gain_sel = lvdt1_gain;
      2'd1:    gain_sel = lvdt2_gain;
      default: gain_sel = pressure_gain;
    endcase
    mul_a = cmd.rate_path ? dmag[cmd.idx[0]] : MUL_A_W'(avg[cmd.idx]);
    mul_b = cmd.rate_path ? RATE_SCALE : gain_sel;

    div_dividend = prod[MAG_W-1:0];
    div_divisor  = elapsed;
    div_iters    = DIV_CNT_W'(MAG_W);

    avg_prod = AVG_PROD_W'(sums[cmd.idx]) * AVG_PROD_W'(AVG_RECIP);

    scaled    = prod[PROD_W-1:Q_SHIFT];
    pos_sat   = (|scaled[SC_W-1:POS_W]) ? {POS_W{1'b1}} : scaled[POS_W-1:0];
    press_sum = {1'b0, scaled} + (SC_W + 1)'(pressure_offset);
    press_sat = (|press_sum[SC_W:PRESS_W]) ? {PRESS_W{1'b1}} : press_sum[PRESS_W-1:0];

    quo_big = |quo[MAG_W-1:RATE_W-1];
    if (dneg[cmd.idx[0]]) begin
      rate_sat = quo_big ? {1'b1, {(RATE_W-1){1'b0}}} : -quo[RATE_W-1:0];
    end else begin
      rate_sat = quo_big ? {1'b0, {(RATE_W-1){1'b1}}} : quo[RATE_W-1:0];
    end

    for (int j = 0; j < 2; j++) begin
      disp_new[j] = calibrated ? ({1'b0, pos[j]} - {1'b0, bias[j]}) : '0;
      diff[j]     = {disp_new[j][DISP_W-1], disp_new[j]} - {last[j][DISP_W-1], last[j]};
      diff_abs[j] = diff[j][DISP_W] ? -diff[j] : diff[j];
    end
  end

  lpfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) sums[i] <= '0;
      for (int j = 0; j < 2; j++) begin
        bias[j] <= '0;
        last[j] <= '0;
      end
      count      <= '0;
      calibrated <= 1'b0;
    end else begin
      if (cmd.accum) begin
        for (int i = 0; i < 4; i++) sums[i] <= sums[i] + SUM_W'(raw[i]);
        count <= status.last_item ? '0 : count + 1'b1;
      end
      if (cmd.avg_store) begin
        sums[cmd.idx] <= '0;
      end
      if (cmd.finish) begin
        if (!calibrated) begin
          for (int j = 0; j < 2; j++) begin
            bias[j] <= pos[j];
            last[j] <= '0;
          end
          calibrated <= 1'b1;
        end else begin
          for (int j = 0; j < 2; j++) last[j] <= disp[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      elapsed <= elapsed_us;
    end
    if (cmd.avg_store) begin
      avg[cmd.idx] <= avg_prod[AVG_SHIFT +: SAMPLE_BITS];
    end
    if (cmd.mul_go) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.scale_store) begin
      if (cmd.idx[1]) begin
        press[cmd.idx[0]] <= press_sat;
      end else begin
        pos[cmd.idx[0]] <= pos_sat;
      end
    end
    if (cmd.disp_calc) begin
      for (int j = 0; j < 2; j++) begin
        disp[j] <= disp_new[j];
        dneg[j] <= diff[j][DISP_W];
        dmag[j] <= diff_abs[j][MUL_A_W-1:0];
        rate[j] <= '0;
      end
    end
    if (cmd.rate_store) begin
      rate[cmd.idx[0]] <= rate_sat;
    end
    if (cmd.finish) begin
      disp1         <= disp[0];
      disp2         <= disp[1];
      rate1         <= rate[0];
      rate2         <= rate[1];
      pressure1     <= press[0];
      pressure2     <= press[1];
      bias_captured <= !calibrated;
      rate_invalid  <= calibrated && status.elapsed_zero;
    end
  end

endmodule

// File: sv/lpfc_ctrl.sv
// Controller: sequences accumulation, averaging, scaling and rate per frame.
module lpfc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  lpfc_pkg::lpfc_status_t   status,
  output lpfc_pkg::lpfc_cmd_t      cmd
);
  import lpfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_LOAD,
    S_SCALE_MUL,
    S_SCALE_STORE,
    S_DISP,
    S_RATE_MUL,
    S_RATE_LOAD,
    S_RATE_WAIT,
    S_DONE
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] ch;
  logic [1:0] ch_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.idx    = ch;
    state_next = state;
    ch_next    = ch;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (status.last_item) begin
            state_next = S_AVG_LOAD;
            ch_next    = 2'd0;
          end
        end
      end
      S_AVG_LOAD: begin
        cmd.avg_store = 1'b1;
        ch_next       = ch + 2'd1;
        state_next    = (ch == 2'd3) ? S_SCALE_MUL : S_AVG_LOAD;
      end
      S_SCALE_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_SCALE_STORE;
      end
      S_SCALE_STORE: begin
        cmd.scale_store = 1'b1;
        ch_next         = ch + 2'd1;
        state_next      = (ch == 2'd3) ? S_DISP : S_SCALE_MUL;
      end
      S_DISP: begin
        cmd.disp_calc = 1'b1;
        ch_next       = 2'd0;
        if (!status.calibrated || status.elapsed_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RATE_MUL;
        end
      end
      S_RATE_MUL: begin
        cmd.rate_path = 1'b1;
        cmd.mul_go    = 1'b1;
        state_next    = S_RATE_LOAD;
      end
      S_RATE_LOAD: begin
        cmd.rate_path = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        cmd.rate_path = 1'b1;
        if (status.div_done) begin
          cmd.rate_store = 1'b1;
          ch_next        = ch + 2'd1;
          state_next     = (ch == 2'd1) ? S_DONE : S_RATE_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/lpfc_checker.sv
// Port-level checker for the frame conditioner, bound to the top level.
module lpfc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [20:0] disp1,
  input logic signed [20:0] disp2,
  input logic signed [31:0] rate1,
  input logic signed [31:0] rate2,
  input logic [15:0]        pressure1,
  input logic [15:0]        pressure2,
  input logic               bias_captured,
  input logic               rate_invalid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(disp1) && $stable(disp2)
      && $stable(rate1) && $stable(rate2) && $stable(pressure1)
      && $stable(pressure2) && $stable(bias_captured) && $stable(rate_invalid))
    else $error("result beat changed while stalled");

  a_bias_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bias_captured |-> disp1 == 0 && disp2 == 0 && rate1 == 0
      && rate2 == 0 && !rate_invalid)
    else $error("bias frame reported nonzero motion");

  a_invalid_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_invalid |-> rate1 == 0 && rate2 == 0)
    else $error("rate reported with zero elapsed time");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lvdt_pressure_frame_conditioner lpfc_checker u_lpfc_checker (.*);
